// File: hw/rtl/vbcr_pkg.sv
// Shared types and constants for the value batch color ramp.
// No dependencies; the core, the divider, the blend unit and the testbench import this package.
package vbcr_pkg;

    // default configuration of the top level
    localparam int DEF_MAX_VALUES  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // blend weight, unsigned Q1.16
    localparam int FRAC_BITS = 16;
    localparam int T_BITS    = FRAC_BITS + 1;
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << FRAC_BITS;

    // divider produces the fraction bits of the weight
    localparam int Q_BITS       = FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(Q_BITS + 1);

    // one color channel of the blend: 8 x 17 products plus rounding
    localparam int CHAN_BITS  = 8;
    localparam int COLOR_BITS = 4 * CHAN_BITS;
    localparam int SUM_BITS   = CHAN_BITS + T_BITS + 1;
    localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (FRAC_BITS - 1);

    // output slot field
    localparam int SLOT_BITS = 6;

    // register bus
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    typedef enum logic [0:0] {
        REG_LOW_COLOR  = 1'b0,
        REG_HIGH_COLOR = 1'b1
    } t_reg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SETUP,
        S_DIV,
        S_BLGO,
        S_BLEND,
        S_PUSH
    } t_state;

    // status of a shared multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

// File: hw/rtl/value_batch_color_ramp_core.sv
// Batch color ramp: samples are stored one per cycle while the running minimum and
// maximum are tracked; the request that carries final_item starts the emission of one
// RGBA color per stored sample, in arrival order, blended between low_color and
// high_color by t = (v - min) / (max - min) in Q1.16. During emission o_in_stall
// stays high; each color passes through the RAM read, setup, 16 steps of the
// bit-serial divider, 4 steps of the shared channel multiply-add unit and the
// output load when the weight must be divided, and skips the divider when the
// weight is 0 or 1.0 or the batch is flat. The output register lets a finished
// color wait while the next one is computed, and input is taken again once the
// last color of the batch sits in that register.
// Depends on vbcr_pkg, vbcr_ram, vbcr_divider and vbcr_blend.
module value_batch_color_ramp_core #(
    parameter int MAX_VALUES  = vbcr_pkg::DEF_MAX_VALUES,
    parameter int SAMPLE_BITS = vbcr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample requests
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_final_item,
    // color results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vbcr_pkg::SLOT_BITS-1:0]    o_slot,
    output logic [vbcr_pkg::CHAN_BITS-1:0]    o_red,
    output logic [vbcr_pkg::CHAN_BITS-1:0]    o_green,
    output logic [vbcr_pkg::CHAN_BITS-1:0]    o_blue,
    output logic [vbcr_pkg::CHAN_BITS-1:0]    o_alpha,
    output logic                              o_overflowed,
    output logic                              o_end_of_run,
    // register bus
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vbcr_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [vbcr_pkg::DATA_BITS-1:0]    pwdata,
    output logic [vbcr_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import vbcr_pkg::*;

    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VALUES);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // control state
    t_state                         r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic signed [SAMPLE_BITS-1:0]  r_min, n_min;
    logic signed [SAMPLE_BITS-1:0]  r_max, n_max;
    logic                           r_ovf, n_ovf;
    logic [CW-1:0]                  r_slot, n_slot;
    logic                           r_out_valid, n_out_valid;

    // payload
    logic [T_BITS-1:0]              r_t, n_t;
    logic [SLOT_BITS-1:0]           r_out_slot, n_out_slot;
    logic [COLOR_BITS-1:0]          r_out_color, n_out_color;
    logic                           r_out_ovf, n_out_ovf;
    logic                           r_out_eor, n_out_eor;

    // configuration
    logic [COLOR_BITS-1:0]          r_low;
    logic [COLOR_BITS-1:0]          r_high;

    logic                           in_accept;
    logic                           out_take;
    logic                           wr_en;
    logic [SAMPLE_BITS-1:0]         rd_data;
    logic signed [SAMPLE_BITS-1:0]  x;
    logic [SAMPLE_BITS:0]           d_wide;
    logic [SAMPLE_BITS:0]           span_wide;
    logic                           flat;
    logic                           last_slot;
    logic                           div_start;
    logic [Q_BITS-1:0]              div_q;
    t_unit_status                   div_st;
    logic                           bl_start;
    logic [COLOR_BITS-1:0]          bl_color;
    t_unit_status                   bl_st;
    logic                           cfg_wr;

    // sample store
    assign wr_en = in_accept && (r_count < MAX_CNT);

    vbcr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_VALUES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_sample),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_slot[AW-1:0]),
        .o_rd_data (rd_data)
    );

    vbcr_divider #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (d_wide[SAMPLE_BITS-1:0]),
        .i_divisor  (span_wide[SAMPLE_BITS-1:0]),
        .o_quot     (div_q),
        .o_status   (div_st)
    );

    vbcr_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (bl_start),
        .i_weight     (r_t),
        .i_low_color  (r_low),
        .i_high_color (r_high),
        .o_color      (bl_color),
        .o_status     (bl_st)
    );

    // offsets from the minimum; both are non-negative where they are used
    always_comb begin
        x         = signed'(rd_data);
        d_wide    = {x[SAMPLE_BITS-1], x} - {r_min[SAMPLE_BITS-1], r_min};
        span_wide = {r_max[SAMPLE_BITS-1], r_max} - {r_min[SAMPLE_BITS-1], r_min};
        flat      = !(r_max > r_min);
        last_slot = ((r_slot + CW'(1)) == r_count);
    end

    // handshakes
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_take  = r_out_valid && !i_out_stall;

    // sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_ovf       = r_ovf;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        n_t         = r_t;
        n_out_slot  = r_out_slot;
        n_out_color = r_out_color;
        n_out_ovf   = r_out_ovf;
        n_out_eor   = r_out_eor;
        div_start   = 1'b0;
        bl_start    = 1'b0;

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (r_count < MAX_CNT) begin
                        n_count = r_count + CW'(1);
                        if (i_sample < r_min) begin
                            n_min = i_sample;
                        end
                        if (i_sample > r_max) begin
                            n_max = i_sample;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final_item) begin
                        n_slot  = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_SETUP;
            end
            S_SETUP: begin
                // weight at the ends of the ramp needs no division
                if (flat || (x <= r_min)) begin
                    n_t     = '0;
                    n_state = S_BLGO;
                end else if (x >= r_max) begin
                    n_t     = T_ONE;
                    n_state = S_BLGO;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_st.done) begin
                    n_t     = {1'b0, div_q};
                    n_state = S_BLGO;
                end
            end
            S_BLGO: begin
                bl_start = 1'b1;
                n_state  = S_BLEND;
            end
            S_BLEND: begin
                if (bl_st.done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || out_take) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = SLOT_BITS'(r_slot);
                    n_out_color = bl_color;
                    n_out_ovf   = r_ovf;
                    n_out_eor   = last_slot;
                    if (last_slot) begin
                        // batch done, back to reset values
                        n_count = '0;
                        n_min   = SAMPLE_TOP;
                        n_max   = SAMPLE_BOTTOM;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_slot  = r_slot + CW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min       <= SAMPLE_TOP;
            r_max       <= SAMPLE_BOTTOM;
            r_ovf       <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_ovf       <= n_ovf;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_out_slot  <= n_out_slot;
        r_out_color <= n_out_color;
        r_out_ovf   <= n_out_ovf;
        r_out_eor   <= n_out_eor;
    end

    // register bus write
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '1;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_LOW_COLOR:  r_low  <= pwdata;
                REG_HIGH_COLOR: r_high <= pwdata;
                default: ;
            endcase
        end
    end

    // register bus read
    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_LOW_COLOR:  prdata = r_low;
            REG_HIGH_COLOR: prdata = r_high;
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // outputs
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_out_slot;
    assign o_red        = r_out_color[3*CHAN_BITS +: CHAN_BITS];
    assign o_green      = r_out_color[2*CHAN_BITS +: CHAN_BITS];
    assign o_blue       = r_out_color[CHAN_BITS +: CHAN_BITS];
    assign o_alpha      = r_out_color[0 +: CHAN_BITS];
    assign o_overflowed = r_out_ovf;
    assign o_end_of_run = r_out_eor;

    // stored count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("stored count beyond capacity");

    // emission never runs on an empty batch
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count != '0))
        else $error("emission with empty batch");

    // the two shared units never work at once
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_st.busy && bl_st.busy))
        else $error("divider and blend unit busy together");

    // a divider result only shows up while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == S_DIV))
        else $error("divider done outside its wait state");

endmodule

// File: hw/rtl/vbcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module vbcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/vbcr_divider.sv
// Restoring divider, one quotient bit per cycle, for the blend weight.
// Depends on vbcr_pkg for the quotient width and the status struct.
module vbcr_divider #(
    parameter int SAMPLE_BITS = vbcr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [SAMPLE_BITS-1:0]         i_dividend,
    input  logic [SAMPLE_BITS-1:0]         i_divisor,
    output logic [vbcr_pkg::Q_BITS-1:0]    o_quot,
    output vbcr_pkg::t_unit_status         o_status
);
    import vbcr_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [SAMPLE_BITS-1:0]  r_rem;
    logic [SAMPLE_BITS-1:0]  r_den;
    logic [Q_BITS-1:0]       r_q;

    logic [SAMPLE_BITS:0]    shifted;
    logic [SAMPLE_BITS:0]    diff;
    logic                    fits;

    // one shift, compare and subtract step; remainder stays below the divisor
    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(Q_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            r_q   <= {r_q[Q_BITS-2:0], fits};
        end
    end

    assign o_quot        = r_q;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// File: hw/rtl/vbcr_blend.sv
// Shared multiply-add unit that blends the two colors one channel per cycle.
// Depends on vbcr_pkg for the weight format and the status struct.
module vbcr_blend (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vbcr_pkg::T_BITS-1:0]       i_weight,
    input  logic [vbcr_pkg::COLOR_BITS-1:0]   i_low_color,
    input  logic [vbcr_pkg::COLOR_BITS-1:0]   i_high_color,
    output logic [vbcr_pkg::COLOR_BITS-1:0]   o_color,
    output vbcr_pkg::t_unit_status            o_status
);
    import vbcr_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [1:0]            r_pos;
    logic [T_BITS-1:0]     r_w;
    logic [COLOR_BITS-1:0] r_color;

    logic [CHAN_BITS-1:0]  chan_lo;
    logic [CHAN_BITS-1:0]  chan_hi;
    logic [T_BITS-1:0]     inv_w;
    logic [SUM_BITS-1:0]   prod_lo;
    logic [SUM_BITS-1:0]   prod_hi;
    logic [SUM_BITS-1:0]   sum;

    // lo*(1-t) + hi*t + half, rounded back to 8 bits
    always_comb begin
        chan_lo = i_low_color[CHAN_BITS*r_pos +: CHAN_BITS];
        chan_hi = i_high_color[CHAN_BITS*r_pos +: CHAN_BITS];
        inv_w   = T_ONE - r_w;
        prod_lo = SUM_BITS'(chan_lo) * SUM_BITS'(inv_w);
        prod_hi = SUM_BITS'(chan_hi) * SUM_BITS'(r_w);
        sum     = prod_lo + prod_hi + ROUND_HALF;
    end

    // channel sequencing, red first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pos  <= 2'd3;
            end else if (r_busy) begin
                r_pos <= r_pos - 2'd1;
                if (r_pos == 2'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // weight capture and channel results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= i_weight;
        end else if (r_busy) begin
            r_color[CHAN_BITS*r_pos +: CHAN_BITS] <= sum[FRAC_BITS +: CHAN_BITS];
        end
    end

    assign o_color       = r_color;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// File: tb/tb_value_batch_color_ramp_core.sv
// Self-checking testbench for the value batch color ramp core.
// Depends on vbcr_pkg and value_batch_color_ramp_core; predicts every color
// in step with accepted sample requests and checks them in order.
`timescale 1ns / 1ps

module tb_value_batch_color_ramp_core;
    import vbcr_pkg::*;

    localparam int SAMPLE_W = DEF_SAMPLE_BITS;
    localparam int CAPACITY = DEF_MAX_VALUES;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } t_sample_req;

    typedef struct {
        logic [SLOT_BITS-1:0] slot;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] alpha;
        logic                 overflowed;
        logic                 end_of_run;
    } t_ramp_color;

    // block ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_final_item = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [SLOT_BITS-1:0]       o_slot;
    logic [CHAN_BITS-1:0]       o_red;
    logic [CHAN_BITS-1:0]       o_green;
    logic [CHAN_BITS-1:0]       o_blue;
    logic [CHAN_BITS-1:0]       o_alpha;
    logic                       o_overflowed;
    logic                       o_end_of_run;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_BITS-1:0]       paddr = '0;
    logic [DATA_BITS-1:0]       pwdata = '0;
    logic [DATA_BITS-1:0]       prdata;
    logic                       pready;

    // stimulus and expectation stores
    t_sample_req pending[$];
    t_ramp_color colors_due[$];
    t_sample_req head_req;
    t_ramp_color want;
    int          mismatch_count = 0;

    // shadow of the block: registers and batch state
    logic [31:0] ramp_lo = 32'h0000_0000;
    logic [31:0] ramp_hi = 32'hFFFF_FFFF;
    int          batch_vals[CAPACITY];
    int          n_stored = 0;
    int          run_min = 32767;
    int          run_max = -32768;
    bit          dropped_any = 1'b0;

    // sender burst and gap counters, receiver stall pattern
    int burst_left = 0;
    int gap_left = 0;
    int stall_kind = 0;
    int stall_run = 0;

    value_batch_color_ramp_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_final_item (i_final_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_slot       (o_slot),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_overflowed (o_overflowed),
        .o_end_of_run (o_end_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 i_clk = ~i_clk;

    // one channel blend, rounded, Q1.16 weight
    function automatic logic [CHAN_BITS-1:0] mix_channel(logic [7:0] a, logic [7:0] b,
                                                          logic [16:0] w);
        logic [31:0] acc;
        acc = 32'(a) * (32'd65536 - 32'(w)) + 32'(b) * 32'(w) + 32'd32768;
        return acc[23:16];
    endfunction

    // store one sample request and, on the final one, queue the whole ramp
    function automatic void predict_colors(logic signed [SAMPLE_W-1:0] v, logic fin);
        longint      span;
        longint      w;
        int          x;
        t_ramp_color c;
        if (n_stored < CAPACITY) begin
            batch_vals[n_stored] = int'(v);
            n_stored++;
            if (int'(v) < run_min) run_min = int'(v);
            if (int'(v) > run_max) run_max = int'(v);
        end else begin
            dropped_any = 1'b1;
        end
        if (!fin) return;
        for (int i = 0; i < n_stored; i++) begin
            w = 0;
            if (run_max > run_min) begin
                x = batch_vals[i];
                span = longint'(run_max) - longint'(run_min);
                if (x <= run_min) w = 0;
                else if (x >= run_max) w = 65536;
                else w = ((longint'(x) - longint'(run_min)) <<< 16) / span;
                if (w > 65536) w = 65536;
            end
            c.slot       = SLOT_BITS'(i);
            c.red        = mix_channel(ramp_lo[31:24], ramp_hi[31:24], 17'(w));
            c.green      = mix_channel(ramp_lo[23:16], ramp_hi[23:16], 17'(w));
            c.blue       = mix_channel(ramp_lo[15:8], ramp_hi[15:8], 17'(w));
            c.alpha      = mix_channel(ramp_lo[7:0], ramp_hi[7:0], 17'(w));
            c.overflowed = dropped_any;
            c.end_of_run = (i + 1 == n_stored);
            colors_due.push_back(c);
        end
        n_stored = 0;
        run_min = 32767;
        run_max = -32768;
        dropped_any = 1'b0;
    endfunction

    task automatic note_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int expected);
        if (got != expected)
            note_error($sformatf("slot %0d %s: got %0h, expected %0h",
                                 want.slot, name, got, expected));
    endtask

    // sample request driver: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_colors(i_sample, i_final_item);
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    head_req = pending.pop_front();
                    i_sample <= head_req.value;
                    i_final_item <= head_req.last;
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: free flow, scattered stalls, or mostly stalled
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_kind <= $urandom_range(0, 2);
            stall_run <= $urandom_range(20, 200);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_kind)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // color monitor: compare against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (colors_due.size() == 0) begin
                note_error($sformatf("color for slot %0d with none expected", o_slot));
            end else begin
                want = colors_due.pop_front();
                check_field("slot", int'(o_slot), int'(want.slot));
                check_field("red", int'(o_red), int'(want.red));
                check_field("green", int'(o_green), int'(want.green));
                check_field("blue", int'(o_blue), int'(want.blue));
                check_field("alpha", int'(o_alpha), int'(want.alpha));
                check_field("overflowed", int'(o_overflowed), int'(want.overflowed));
                check_field("end_of_run", int'(o_end_of_run), int'(want.end_of_run));
            end
        end
    end

    // register write: setup then access cycle
    task automatic write_color(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LOW_COLOR) ramp_lo = val;
        else ramp_hi = val;
    endtask

    task automatic queue_sample(logic [SAMPLE_W-1:0] v, logic fin);
        t_sample_req r;
        r.value = v;
        r.last = fin;
        pending.push_back(r);
    endtask

    // wait until every request is taken and every color is back, then settle
    task automatic drain();
        do @(negedge i_clk);
        while (pending.size() != 0 || i_in_valid || colors_due.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0]         lo_set[5];
        logic [31:0]         hi_set[5];
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] v;
        int                  queued;
        int                  len;
        int                  kind;
        lo_set[0] = 32'h0000_0000;
        hi_set[0] = 32'hFFFF_FFFF;
        lo_set[1] = 32'hFFFF_FFFF;
        hi_set[1] = 32'h0000_0000;
        lo_set[2] = $urandom;
        hi_set[2] = $urandom;
        lo_set[3] = $urandom;
        hi_set[3] = lo_set[3];
        lo_set[4] = $urandom;
        hi_set[4] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            // phase 0 keeps the reset colors, the others rewrite both
            if (ph > 0) begin
                write_color(REG_LOW_COLOR, lo_set[ph]);
                write_color(REG_HIGH_COLOR, hi_set[ph]);
            end
            if (ph == 0) begin
                // full range with both extremes and mid points
                queue_sample(16'h8000, 1'b0);
                queue_sample(16'h7FFF, 1'b0);
                queue_sample(16'h0000, 1'b0);
                queue_sample(16'hFFFF, 1'b0);
                queue_sample(16'h0001, 1'b0);
                queue_sample(16'h4000, 1'b0);
                queue_sample(16'hBFFF, 1'b1);
                // single sample batch is flat
                queue_sample(16'h0005, 1'b1);
                // flat batch at the most negative value
                queue_sample(16'h8000, 1'b0);
                queue_sample(16'h8000, 1'b0);
                queue_sample(16'h8000, 1'b1);
                // top of range, span of one
                queue_sample(16'h7FFF, 1'b0);
                queue_sample(16'h7FFE, 1'b1);
                // span of one around zero, repeated minimum value
                queue_sample(16'h0000, 1'b0);
                queue_sample(16'h0001, 1'b0);
                queue_sample(16'h0000, 1'b1);
            end
            if (ph == 1) begin
                // capacity exceeded, final request itself dropped
                for (int k = 0; k < CAPACITY + 2; k++)
                    queue_sample(16'($urandom_range(0, 65535)), k == CAPACITY + 1);
            end
            queued = 0;
            while (queued < 50) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 4)
                                                 : $urandom_range(1, 12);
                kind = $urandom_range(0, 3);
                base = SAMPLE_W'($urandom_range(0, 65535));
                for (int k = 0; k < len; k++) begin
                    case (kind)
                        0: v = SAMPLE_W'($urandom_range(0, 65535));
                        1: v = base + SAMPLE_W'($urandom_range(0, 7));
                        2: begin
                            case ($urandom_range(0, 3))
                                0: v = 16'h8000;
                                1: v = 16'h7FFF;
                                2: v = 16'h0000;
                                default: v = 16'hFFFF;
                            endcase
                        end
                        default: v = base;
                    endcase
                    queue_sample(v, k == len - 1);
                end
                queued += len;
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hang guard
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/vbcr_pkg.sv
hw/rtl/vbcr_ram.sv
hw/rtl/vbcr_divider.sv
hw/rtl/vbcr_blend.sv
hw/rtl/value_batch_color_ramp_core.sv
tb/tb_value_batch_color_ramp_core.sv
